@@ src/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// shared codes and types of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_MEM     = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR   = 3'd2;
  localparam logic [2:0] ST_BAD_ORDER  = 3'd3;
  localparam logic [2:0] ST_ALREADY_FR = 3'd4;

  localparam logic [4:0]  TAG_NOT_FREE = 5'd31;
  localparam logic [12:0] LINK_NONE    = 13'h1FFF;
  localparam int          PAGE_SHIFT   = 12;

  localparam logic [0:0] CFG_BASE_ADDR  = 1'd0;
  localparam logic [0:0] CFG_PAGE_COUNT = 1'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  ord;
    logic        ord_bad;
    logic        addr_bad;
    logic [12:0] page;
  } bpa_req_t;

endpackage

@@ src/bpa_front.sv @@
// ----------------------------------------------------------------------------
// bpa_front
// accepts requests, checks order and address range, builds queue entries
// ----------------------------------------------------------------------------
module bpa_front import bpa_pkg::*; #(
  parameter int MAX_ORDER_NUM = 11,
  parameter int MAX_PAGES     = 4096
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_order,
  input  logic [31:0] in_address,
  input  logic [31:0] base_addr,
  input  logic [12:0] page_count,
  input  logic        q_full,
  input  logic        clearing,
  output logic        push,
  output bpa_req_t    entry
);

  logic [12:0] usable;
  logic [31:0] diff;
  logic [19:0] idx;

  assign usable = (page_count > 13'(MAX_PAGES)) ? 13'(MAX_PAGES) : page_count;
  assign diff   = in_address - base_addr;
  assign idx    = diff[31:PAGE_SHIFT];

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    entry.cmd      = in_cmd;
    entry.ord      = in_order;
    entry.ord_bad  = {1'b0, in_order} >= 5'(MAX_ORDER_NUM);
    entry.addr_bad = (in_address < base_addr) || (idx >= {7'd0, usable});
    entry.page     = idx[12:0];
  end

endmodule

@@ src/bpa_queue.sv @@
// ----------------------------------------------------------------------------
// bpa_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module bpa_queue import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bpa_req_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output bpa_req_t pop_entry
);

  bpa_req_t   mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign valid     = cnt_r != 2'd0;
  assign pop_entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/bpa_back.sv @@
// ----------------------------------------------------------------------------
// bpa_back
// sequencer over tag and link memories: alloc, free with merge, init
// ----------------------------------------------------------------------------
module bpa_back import bpa_pkg::*; #(
  parameter int MAX_ORDER_NUM = 11,
  parameter int MAX_PAGES     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] base_addr,
  input  logic [12:0] page_count,
  input  logic        q_valid,
  input  bpa_req_t    q_entry,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_address_res,
  output logic [12:0] out_free_count
);

  localparam int PW = $clog2(MAX_PAGES);
  localparam int OW = (MAX_ORDER_NUM > 1) ? $clog2(MAX_ORDER_NUM) : 1;
  localparam logic [12:0] MAXP = 13'(MAX_PAGES);
  localparam logic [4:0]  MAXO = 5'(MAX_ORDER_NUM);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_F_TAG = 5'd2;
  localparam logic [4:0] S_R_CHK = 5'd3;
  localparam logic [4:0] S_R_TAG = 5'd4;
  localparam logic [4:0] S_R_UNL = 5'd5;
  localparam logic [4:0] S_R_WR  = 5'd6;
  localparam logic [4:0] S_PUSH1 = 5'd7;
  localparam logic [4:0] S_PUSH2 = 5'd8;
  localparam logic [4:0] S_POST  = 5'd9;
  localparam logic [4:0] S_INIT  = 5'd10;
  localparam logic [4:0] S_A_SRC = 5'd11;
  localparam logic [4:0] S_A_POP = 5'd12;
  localparam logic [4:0] S_A_TAG = 5'd13;
  localparam logic [4:0] S_A_SPL = 5'd14;
  localparam logic [4:0] S_S_TAG = 5'd15;

  logic [4:0]  tag_mem [MAX_PAGES];
  logic [12:0] nxt_mem [MAX_PAGES];
  logic [12:0] prv_mem [MAX_PAGES];

  logic          tag_we, nxt_we, prv_we;
  logic [PW-1:0] tag_wa, nxt_wa, prv_wa, tag_ra, nxt_ra, prv_ra;
  logic [4:0]    tag_wd, tag_rd;
  logic [12:0]   nxt_wd, nxt_rd, prv_wd, prv_rd;

  logic [4:0]  state_r;
  logic [12:0] cnt_r, p_r, n_r, pv_r, h_r, pq_r, hd_r, iidx_r, fpc_r;
  logic [3:0]  o_r, st_ord_r, it_r, cur_r, po_r;
  logic        ret_r, init_r, fbad_r;
  logic [12:0] head_r [MAX_ORDER_NUM];

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [12:0] out_free_r;
  logic        res_load, out_valid_nxt;

  logic [12:0] usable, bud, swp_base, swp_idx, swp_end, head_it;
  logic        merge_ok;

  assign usable   = (page_count > MAXP) ? MAXP : page_count;
  assign bud      = p_r ^ (13'd1 << o_r);
  assign merge_ok = (({1'b0, o_r} + 5'd1) < MAXO) && (bud < usable);
  assign head_it  = head_r[it_r[OW-1:0]];

  always_comb begin
    unique case (state_r)
      S_R_WR:  swp_base = p_r;
      S_A_TAG: swp_base = h_r;
      S_S_TAG: swp_base = pq_r;
      default: swp_base = 13'd0;
    endcase
  end
  assign swp_idx = swp_base + cnt_r;

  always_comb begin
    unique case (state_r)
      S_R_WR:  swp_end = (13'd1 << o_r) - 13'd1;
      S_S_TAG: swp_end = (13'd1 << po_r) - 13'd1;
      default: swp_end = (13'd1 << o_r) - 13'd1;
    endcase
  end

  // result register load
  always_comb begin
    unique case (state_r)
      S_IDLE:  res_load = q_pop && ((q_entry.cmd == CMD_ALLOC && q_entry.ord_bad) ||
                                    (q_entry.cmd == CMD_FREE && q_entry.addr_bad) ||
                                    (q_entry.cmd != CMD_ALLOC && q_entry.cmd != CMD_FREE &&
                                     q_entry.cmd != CMD_INIT));
      S_F_TAG: res_load = (tag_rd != TAG_NOT_FREE) || fbad_r;
      S_POST:  res_load = !ret_r && !init_r;
      S_INIT:  res_load = !(iidx_r < usable);
      S_A_SRC: res_load = {1'b0, it_r} >= MAXO;
      S_A_SPL: res_load = !(cur_r > o_r);
      default: res_load = 1'b0;
    endcase
  end
  assign out_valid_nxt = res_load || (out_valid_r && !out_ready);

  assign clearing        = (state_r == S_CLR) && !init_r;
  assign q_pop           = (state_r == S_IDLE) && q_valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address_res = out_addr_r;
  assign out_free_count  = out_free_r;

  // memory port control
  always_comb begin
    tag_we = 1'b0; tag_wa = swp_idx[PW-1:0]; tag_wd = TAG_NOT_FREE;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    tag_ra = bud[PW-1:0];
    nxt_ra = bud[PW-1:0];
    prv_ra = bud[PW-1:0];
    unique case (state_r)
      S_CLR: begin
        tag_we = 1'b1;
        tag_wa = cnt_r[PW-1:0];
      end
      S_IDLE: begin
        tag_ra = q_entry.page[PW-1:0];
      end
      S_R_TAG: begin
        if (tag_rd == {1'b0, o_r} && prv_rd < MAXP) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd[PW-1:0];
          nxt_wd = nxt_rd;
        end
      end
      S_R_UNL: begin
        if (n_r < MAXP) begin
          prv_we = 1'b1;
          prv_wa = n_r[PW-1:0];
          prv_wd = pv_r;
        end
      end
      S_R_WR: begin
        tag_we = swp_idx < MAXP;
        tag_wd = {1'b0, o_r};
      end
      S_A_TAG: begin
        tag_we = swp_idx < MAXP;
      end
      S_S_TAG: begin
        tag_we = swp_idx < MAXP;
        tag_wd = {1'b0, po_r};
      end
      S_PUSH1: begin
        if (pq_r < MAXP) begin
          nxt_we = 1'b1;
          nxt_wa = pq_r[PW-1:0];
          nxt_wd = head_r[po_r[OW-1:0]];
          prv_we = 1'b1;
          prv_wa = pq_r[PW-1:0];
          prv_wd = LINK_NONE;
        end
      end
      S_PUSH2: begin
        if (hd_r < MAXP) begin
          prv_we = 1'b1;
          prv_wa = hd_r[PW-1:0];
          prv_wd = pq_r;
        end
      end
      S_A_SRC: begin
        nxt_ra = head_it[PW-1:0];
      end
      S_A_POP: begin
        if (nxt_rd < MAXP) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd[PW-1:0];
          prv_wd = LINK_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd <= prv_mem[prv_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= 13'd0;
      init_r      <= 1'b0;
      fpc_r       <= 13'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ORDER_NUM; i++) head_r[i] <= LINK_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_CLR: begin
          if (cnt_r == MAXP - 13'd1) begin
            iidx_r  <= 13'd0;
            state_r <= init_r ? S_INIT : S_IDLE;
          end else begin
            cnt_r <= cnt_r + 13'd1;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            o_r      <= q_entry.ord;
            it_r     <= q_entry.ord;
            st_ord_r <= q_entry.ord;
            p_r      <= q_entry.page;
            fbad_r   <= q_entry.ord_bad;
            case (q_entry.cmd)
              CMD_ALLOC: begin
                if (q_entry.ord_bad) begin
                  out_status_r <= ST_BAD_ORDER;
                  out_addr_r   <= 32'd0;
                  out_free_r   <= fpc_r;
                end else begin
                  state_r <= S_A_SRC;
                end
              end
              CMD_FREE: begin
                if (q_entry.addr_bad) begin
                  out_status_r <= ST_BAD_ADDR;
                  out_addr_r   <= 32'd0;
                  out_free_r   <= fpc_r;
                end else begin
                  state_r <= S_F_TAG;
                end
              end
              CMD_INIT: begin
                for (int i = 0; i < MAX_ORDER_NUM; i++) head_r[i] <= LINK_NONE;
                fpc_r   <= 13'd0;
                cnt_r   <= 13'd0;
                init_r  <= 1'b1;
                state_r <= S_CLR;
              end
              default: begin
                out_status_r <= ST_OK;
                out_addr_r   <= 32'd0;
                out_free_r   <= fpc_r;
              end
            endcase
          end
        end
        S_F_TAG: begin
          if (tag_rd != TAG_NOT_FREE || fbad_r) begin
            out_status_r <= (tag_rd != TAG_NOT_FREE) ? ST_ALREADY_FR : ST_BAD_ORDER;
            out_addr_r   <= 32'd0;
            out_free_r   <= fpc_r;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_R_CHK;
          end
        end
        S_R_CHK: begin
          cnt_r   <= 13'd0;
          state_r <= merge_ok ? S_R_TAG : S_R_WR;
        end
        S_R_TAG: begin
          if (tag_rd == {1'b0, o_r}) begin
            n_r  <= nxt_rd;
            pv_r <= prv_rd;
            if (prv_rd >= MAXP) head_r[o_r[OW-1:0]] <= nxt_rd;
            state_r <= S_R_UNL;
          end else begin
            state_r <= S_R_WR;
          end
        end
        S_R_UNL: begin
          p_r     <= p_r & ~(13'd1 << o_r);
          o_r     <= o_r + 4'd1;
          state_r <= S_R_CHK;
        end
        S_R_WR: begin
          if (cnt_r == swp_end) begin
            pq_r    <= p_r;
            po_r    <= o_r;
            ret_r   <= 1'b0;
            state_r <= S_PUSH1;
          end else begin
            cnt_r <= cnt_r + 13'd1;
          end
        end
        S_PUSH1: begin
          if (pq_r < MAXP) begin
            hd_r                <= head_r[po_r[OW-1:0]];
            head_r[po_r[OW-1:0]] <= pq_r;
            state_r             <= S_PUSH2;
          end else begin
            state_r <= S_POST;
          end
        end
        S_PUSH2: begin
          state_r <= S_POST;
        end
        S_POST: begin
          cnt_r <= 13'd0;
          if (ret_r) begin
            state_r <= S_S_TAG;
          end else begin
            fpc_r <= fpc_r + (13'd1 << st_ord_r);
            if (init_r) begin
              iidx_r  <= iidx_r + 13'd1;
              state_r <= S_INIT;
            end else begin
              out_status_r <= ST_OK;
              out_addr_r   <= 32'd0;
              out_free_r   <= fpc_r + (13'd1 << st_ord_r);
              state_r      <= S_IDLE;
            end
          end
        end
        S_INIT: begin
          if (iidx_r < usable) begin
            p_r      <= iidx_r;
            o_r      <= 4'd0;
            st_ord_r <= 4'd0;
            state_r  <= S_R_CHK;
          end else begin
            init_r       <= 1'b0;
            out_status_r <= ST_OK;
            out_addr_r   <= 32'd0;
            out_free_r   <= fpc_r;
            state_r      <= S_IDLE;
          end
        end
        S_A_SRC: begin
          if ({1'b0, it_r} >= MAXO) begin
            out_status_r <= ST_NO_MEM;
            out_addr_r   <= 32'd0;
            out_free_r   <= fpc_r;
            state_r      <= S_IDLE;
          end else if (head_it >= MAXP) begin
            it_r <= it_r + 4'd1;
          end else begin
            h_r     <= head_it;
            state_r <= S_A_POP;
          end
        end
        S_A_POP: begin
          head_r[it_r[OW-1:0]] <= nxt_rd;
          fpc_r   <= fpc_r - (13'd1 << o_r);
          cnt_r   <= 13'd0;
          state_r <= S_A_TAG;
        end
        S_A_TAG: begin
          if (cnt_r == swp_end) begin
            cur_r   <= it_r;
            state_r <= S_A_SPL;
          end else begin
            cnt_r <= cnt_r + 13'd1;
          end
        end
        S_A_SPL: begin
          if (cur_r > o_r) begin
            pq_r    <= h_r + (13'd1 << (cur_r - 4'd1));
            po_r    <= cur_r - 4'd1;
            cur_r   <= cur_r - 4'd1;
            ret_r   <= 1'b1;
            state_r <= S_PUSH1;
          end else begin
            out_free_r  <= fpc_r;
            if (h_r >= usable) begin
              out_status_r <= ST_BAD_ADDR;
              out_addr_r   <= 32'd0;
            end else begin
              out_status_r <= ST_OK;
              out_addr_r   <= base_addr + ({19'd0, h_r} << PAGE_SHIFT);
            end
            state_r <= S_IDLE;
          end
        end
        S_S_TAG: begin
          if (cnt_r == swp_end) begin
            state_r <= S_A_SPL;
          end else begin
            cnt_r <= cnt_r + 13'd1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator
// flow: each request passes the two-entry queue; an invalid request sets the result
//   register when popped, a free is first checked on its tag; free merges buddies,
//   then tags the final block; alloc pops a block, tags it and pushes each split half
// throughput: one request at a time, the next one starts after the result is out
// init: a tag memory clearing pass, then each usable page is freed at order 0
// reset: tag memory clearing pass over all MAX_PAGES entries, input held not ready
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int MAX_ORDER_NUM = 11,
  parameter int MAX_PAGES     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_order,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_address_res,
  output logic [12:0] out_free_count
);

  logic [31:0] base_addr_r;
  logic [12:0] page_count_r;
  logic        push, q_full, q_valid, q_pop, clearing;
  bpa_req_t    push_entry, q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r  <= 32'd0;
      page_count_r <= 13'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ADDR:  base_addr_r  <= cfg_wdata;
        CFG_PAGE_COUNT: page_count_r <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  bpa_front #(
    .MAX_ORDER_NUM(MAX_ORDER_NUM),
    .MAX_PAGES(MAX_PAGES)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_order(in_order),
    .in_address(in_address),
    .base_addr(base_addr_r),
    .page_count(page_count_r),
    .q_full(q_full),
    .clearing(clearing),
    .push(push),
    .entry(push_entry)
  );

  bpa_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_entry(push_entry),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .pop_entry(q_entry)
  );

  bpa_back #(
    .MAX_ORDER_NUM(MAX_ORDER_NUM),
    .MAX_PAGES(MAX_PAGES)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .base_addr(base_addr_r),
    .page_count(page_count_r),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop(q_pop),
    .clearing(clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_address_res(out_address_res),
    .out_free_count(out_free_count)
  );

endmodule

@@ verif/buddy_page_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb
// Self-checking bench for the buddy page allocator. Requests go in through a
// valid/ready driver and results come back through a monitor. Each result is
// checked against a predictor that keeps its own copy of the order tags, the
// free lists and the free-page count. Directed requests come first, then
// random phases over several memory layouts with varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int ORDERS = 11;
  localparam int TABLE  = 4096;
  localparam int LIMIT  = 6_000_000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  ord;
    logic [31:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [12:0] free_count;
  } page_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_BASE_ADDR;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_ALLOC;
  logic [3:0]  in_order = '0;
  logic [31:0] in_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_address_res;
  logic [12:0] out_free_count;

  buddy_page_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_order(in_order), .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_address_res(out_address_res),
    .out_free_count(out_free_count)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [4:0]  tag_q [TABLE];
  logic [12:0] nxt_q [TABLE];
  logic [12:0] prv_q [TABLE];
  bit          linked_q [TABLE];
  logic [12:0] head_q [ORDERS];
  logic [12:0] free_cnt;
  logic [31:0] base_r;
  logic [12:0] pages_r;

  page_req_t   pend_reqs [$];
  page_res_t   exp_results [$];
  int unsigned own_pg [$];
  int unsigned own_ord [$];

  int          errors = 0;
  int unsigned cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  bit          in_acc = 0;
  page_req_t   drv_req;
  page_res_t   mon_exp;

  function automatic int unsigned usable();
    return (pages_r > TABLE) ? TABLE : pages_r;
  endfunction

  task automatic set_tags(input int unsigned s, input int unsigned n, input logic [4:0] t);
    for (int unsigned i = 0; i < n; i++)
      if (s + i < TABLE) tag_q[s + i] = t;
  endtask

  task automatic push_blk(input int unsigned p, input int unsigned o);
    int unsigned h;
    if (p >= TABLE) return;
    h = head_q[o];
    nxt_q[p] = h[12:0];
    prv_q[p] = LINK_NONE;
    linked_q[p] = 1;
    if (h < TABLE) prv_q[h] = p[12:0];
    head_q[o] = p[12:0];
  endtask

  task automatic unlink_blk(input int unsigned x, input int unsigned o);
    int unsigned n, pv;
    n = nxt_q[x];
    pv = prv_q[x];
    if (pv < TABLE) nxt_q[pv] = n[12:0];
    else head_q[o] = n[12:0];
    if (n < TABLE) prv_q[n] = pv[12:0];
  endtask

  task automatic release_blk(input int unsigned p, input int unsigned o);
    int unsigned so, b, lim;
    so = o;
    lim = usable();
    while (o + 1 < ORDERS) begin
      b = p ^ (1 << o);
      if (b >= lim || tag_q[b] != 5'(o)) break;
      unlink_blk(b, o);
      p &= ~(1 << o);
      o++;
    end
    set_tags(p, 1 << o, 5'(o));
    push_blk(p, o);
    free_cnt = free_cnt + 13'(1 << so);
  endtask

  task automatic clear_tbl();
    for (int i = 0; i < TABLE; i++) begin
      tag_q[i] = TAG_NOT_FREE;
      nxt_q[i] = '0;
      prv_q[i] = '0;
      linked_q[i] = 0;
    end
    for (int i = 0; i < ORDERS; i++) head_q[i] = LINK_NONE;
    free_cnt = '0;
  endtask

  task automatic model_alloc(input int unsigned o, output logic [2:0] st,
                             output logic [31:0] a);
    int unsigned h, n, cur, q;
    a = '0;
    st = ST_NO_MEM;
    if (o >= ORDERS) begin
      st = ST_BAD_ORDER;
      return;
    end
    for (int it = o; it < ORDERS; it++) begin
      h = head_q[it];
      if (h >= TABLE) continue;
      n = nxt_q[h];
      head_q[it] = n[12:0];
      if (n < TABLE) prv_q[n] = LINK_NONE;
      set_tags(h, 1 << o, TAG_NOT_FREE);
      free_cnt = free_cnt - 13'(1 << o);
      cur = it;
      while (cur > o) begin
        cur--;
        q = h + (1 << cur);
        push_blk(q, cur);
        set_tags(q, 1 << cur, 5'(cur));
      end
      if (h >= usable()) st = ST_BAD_ADDR;
      else begin
        st = ST_OK;
        a = base_r + 32'(h << PAGE_SHIFT);
      end
      return;
    end
  endtask

  task automatic model_free(input logic [31:0] addr, input int unsigned o,
                            output logic [2:0] st);
    int unsigned idx;
    st = ST_OK;
    if (addr < base_r) st = ST_BAD_ADDR;
    else begin
      idx = (addr - base_r) >> PAGE_SHIFT;
      if (idx >= usable()) st = ST_BAD_ADDR;
      else if (tag_q[idx] != TAG_NOT_FREE) st = ST_ALREADY_FR;
      else if (o >= ORDERS) st = ST_BAD_ORDER;
      else release_blk(idx, o);
    end
  endtask

  // a merge must never unlink a buddy whose links were never written
  function automatic bit merge_ok(input logic [31:0] addr, input int unsigned o);
    int unsigned p, b, lim;
    lim = usable();
    if (addr < base_r) return 1;
    p = (addr - base_r) >> PAGE_SHIFT;
    if (p >= lim || tag_q[p] != TAG_NOT_FREE || o >= ORDERS) return 1;
    while (o + 1 < ORDERS) begin
      b = p ^ (1 << o);
      if (b >= lim || tag_q[b] != 5'(o)) break;
      if (!linked_q[b]) return 0;
      p &= ~(1 << o);
      o++;
    end
    return 1;
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic [3:0] ord, input logic [31:0] addr);
    page_req_t r;
    page_res_t e;
    r = '{cmd: cmd, ord: ord, addr: addr};
    e = '0;
    case (cmd)
      CMD_ALLOC: begin
        model_alloc(ord, e.status, e.addr);
        if (e.status == ST_OK) begin
          own_pg.push_back((e.addr - base_r) >> PAGE_SHIFT);
          own_ord.push_back(ord);
        end
      end
      CMD_FREE: model_free(addr, ord, e.status);
      CMD_INIT: begin
        clear_tbl();
        own_pg.delete();
        own_ord.delete();
        for (int unsigned i = 0; i < usable(); i++) release_blk(i, 0);
      end
      default: e.status = ST_OK;
    endcase
    e.free_count = free_cnt;
    pend_reqs.push_back(r);
    exp_results.push_back(e);
  endtask

  task automatic free_safe(input logic [31:0] addr, input logic [3:0] ord);
    if (merge_ok(addr, ord)) issue(CMD_FREE, ord, addr);
    else issue(CMD_ALLOC, 4'd0, $urandom);
  endtask

  task automatic free_owned(input bit exact);
    int k;
    logic [3:0] o;
    k = $urandom_range(0, own_pg.size() - 1);
    o = exact ? 4'(own_ord[k]) : 4'($urandom_range(0, 15));
    free_safe(base_r + (own_pg[k] << PAGE_SHIFT) + $urandom_range(0, 4095), o);
    own_pg.delete(k);
    own_ord.delete(k);
  endtask

  task automatic rand_item();
    int r, r2;
    r = $urandom_range(0, 199);
    r2 = $urandom_range(0, 99);
    if (r < 90) begin
      if (r2 < 80) issue(CMD_ALLOC, 4'($urandom_range(0, 3)), $urandom);
      else if (r2 < 95) issue(CMD_ALLOC, 4'($urandom_range(4, 10)), $urandom);
      else issue(CMD_ALLOC, 4'($urandom_range(11, 15)), $urandom);
    end else if (r < 160 && own_pg.size() > 0) begin
      free_owned(r2 < 85);
    end else if (r < 180) begin
      if (r2 < 40) free_safe($urandom, 4'($urandom_range(0, 15)));
      else free_safe(base_r + ($urandom_range(0, usable() + 4) << PAGE_SHIFT)
                     + $urandom_range(0, 4095), 4'($urandom_range(0, 15)));
    end else if (r < 190) begin
      issue(2'd3, 4'($urandom_range(0, 15)), $urandom);
    end else if (r < 199) begin
      issue(CMD_ALLOC, 4'($urandom_range(0, 15)), $urandom);
    end else begin
      issue(CMD_INIT, 4'($urandom_range(0, 15)), $urandom);
    end
  endtask

  task automatic wait_drained(input int tail);
    while (pend_reqs.size() != 0 || exp_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_BASE_ADDR) base_r = val;
    else pages_r = val[12:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_layout(input logic [31:0] base, input logic [12:0] pages);
    wait_drained(8);
    cfg_write(CFG_BASE_ADDR, base);
    cfg_write(CFG_PAGE_COUNT, {19'd0, pages});
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [12:0] pages,
                           input int n, input int mode);
    set_layout(base, pages);
    send_idle = (mode == 0) ? 24 : (mode == 1) ? 81 : 0;
    recv_idle = (mode == 0) ? 81 : (mode == 1) ? 24 : 0;
    issue(CMD_INIT, 4'd0, 32'd0);
    for (int i = 0; i < n; i++) rand_item();
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (pend_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        drv_req = pend_reqs.pop_front();
        in_valid <= 1'b1;
        in_cmd <= drv_req.cmd;
        in_order <= drv_req.ord;
        in_address <= drv_req.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_req && out_valid) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_acc = in_valid && in_ready;
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        $error("unexpected result transfer, status %0d", out_status);
        errors++;
      end else begin
        mon_exp = exp_results.pop_front();
        if (out_status !== mon_exp.status) begin
          $error("status exp %0d got %0d", mon_exp.status, out_status);
          errors++;
        end
        if (out_address_res !== mon_exp.addr) begin
          $error("address_res exp %h got %h", mon_exp.addr, out_address_res);
          errors++;
        end
        if (out_free_count !== mon_exp.free_count) begin
          $error("free_count exp %0d got %0d", mon_exp.free_count, out_free_count);
          errors++;
        end
      end
    end
  end

  initial begin
    base_r = '0;
    pages_r = '0;
    clear_tbl();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: 64 pages
    set_layout(32'h0010_0000, 13'd64);
    issue(CMD_INIT, 4'd0, 32'd0);
    issue(CMD_ALLOC, 4'd0, 32'd0);
    issue(CMD_ALLOC, 4'd10, 32'd0);
    issue(CMD_ALLOC, 4'd6, 32'd0);
    issue(CMD_ALLOC, 4'd5, 32'd0);
    issue(CMD_ALLOC, 4'd3, 32'd0);
    free_safe(32'h0010_0ABC, 4'd0);
    free_safe(32'h0010_0000, 4'd0);
    free_safe(32'h0012_0000, 4'd11);
    free_safe(32'h000F_FFFC, 4'd0);
    free_safe(32'h0014_0000, 4'd0);
    issue(CMD_ALLOC, 4'd15, 32'd0);
    issue(CMD_ALLOC, 4'd11, 32'd0);
    issue(2'd3, 4'd15, 32'hFFFF_FFFF);
    free_safe(32'h0012_0000, 4'd5);
    issue(CMD_ALLOC, 4'd0, 32'd0);
    free_safe(base_r + (own_pg[own_pg.size() - 1] << PAGE_SHIFT), 4'd2);
    while (own_pg.size() > 0) free_owned(1);

    // popped block beyond the managed pages
    set_layout(32'h0000_0000, 13'd8);
    issue(CMD_INIT, 4'd0, 32'd0);
    set_layout(32'h0000_0000, 13'd2);
    issue(CMD_ALLOC, 4'd0, 32'd0);
    issue(CMD_ALLOC, 4'd2, 32'd0);
    issue(CMD_ALLOC, 4'd1, 32'd0);

    run_phase(32'h0040_0000, 13'd64, 300, 0);
    hold_req = 1;
    run_phase(32'h8000_0000, 13'd4096, 300, 0);
    run_phase(32'hFFFF_F000, 13'd16, 300, 1);
    run_phase({20'($urandom_range(0, 20'hFFFFF)), 12'h000},
              13'($urandom_range(1, 200)), 300, 1);
    run_phase(32'h1234_5000, 13'd0, 250, 2);
    run_phase(32'h0000_1000, 13'd255, 300, 2);

    wait_drained(40);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
